@@ design/pip_pkg.sv @@
// Package for the point-in-polygon test: word types, opcodes, status codes and constants.
package pip_pkg;

  localparam int unsigned COORD_W          = 32;
  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MIN_VERTICES     = 3;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEST   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FEW  = 2'd1,
    STATUS_DROP = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
  } out_word_t;

endpackage

@@ design/point_in_polygon_test.sv @@
// Top level of the even-odd ray casting point-in-polygon test with its vertex memory.
//
//   Port group  | Direction | Handshake              | Word
//   ------------+-----------+------------------------+---------------------------------
//   input       | in        | in_valid_i, in_stall_o | in_word_i  (func, coord_x, coord_z)
//   result      | out       | out_valid_o, out_stall_i | out_word_o (inside_res, status)
//
// A start or append word writes one vertex; an append to a full table sets the drop flag.
// A test word with n stored vertices makes one read of the last vertex, then one read per
// vertex through the single read port, drains the difference, product and compare stages,
// and posts the result; with fewer than three vertices it goes straight to posting.
// Reset clears the vertex count and the drop flag; the vertex memory itself is not
// cleared, since only entries below the count are ever read.
// While a test walks the memory the input is stalled, and a test whose result finds the
// previous one still waiting holds the input stalled until the output register frees.
// A finished result sits in the output register, and start and append words are still
// taken while it waits.

module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DIF_W = COORD_W + 1;
  localparam int unsigned PRD_W = 2 * DIF_W;
  localparam int unsigned MEM_W = 2 * COORD_W;

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRIME = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic                   few_q, few_d;
  logic signed [COORD_W-1:0] px_q, pz_q;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   parity_q, parity_d;

  logic                   out_valid_q, out_valid_d;
  out_word_t              out_word_q, out_word_d;

  // Vertex memory: x in the upper half, z in the lower half of each entry.
  logic [MEM_W-1:0]       mem_q [MAX_VERTICES];
  logic [MEM_W-1:0]       rd_data_q;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [MEM_W-1:0]       wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   rd_first;
  logic                   rd_vld_q, rd_first_q;

  // Edge pipeline.
  logic signed [COORD_W-1:0] prev_x_q, prev_z_q;
  logic signed [COORD_W-1:0] cur_x, cur_z;
  logic                   straddle;
  logic                   s1_vld_q, s1_vld_d;
  logic                   s1_dzpos_q;
  logic signed [DIF_W-1:0] s1_a_q, s1_b_q, s1_c_q, s1_d_q;
  logic                   s2_vld_q;
  logic                   s2_dzpos_q;
  logic signed [PRD_W-1:0] s2_p1_q, s2_p2_q;
  logic                   toggle;

  logic                   in_acc;
  logic                   out_free;
  logic [CNT_W-1:0]       n_m1;
  logic                   pipe_busy;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign n_m1      = n_q - CNT_W'(1);
  assign pipe_busy = rd_vld_q || s1_vld_q || s2_vld_q;

  // Table fill, test launch and result posting.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    few_d       = few_q;
    rd_idx_d    = rd_idx_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = {in_word_i.coord_x, in_word_i.coord_z};
    rd_en       = 1'b0;
    rd_addr     = rd_idx_q;
    rd_first    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_word_i.func)
            FUNC_START: begin
              wr_en   = 1'b1;
              wr_addr = '0;
              count_d = CNT_W'(1);
              ovf_d   = 1'b0;
            end
            FUNC_APPEND: begin
              if (count_q < CNT_W'(MAX_VERTICES)) begin
                wr_en   = 1'b1;
                wr_addr = count_q[IDX_W-1:0];
                count_d = count_q + CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            FUNC_TEST: begin
              n_d      = count_q;
              few_d    = (count_q < CNT_W'(MIN_VERTICES));
              rd_idx_d = '0;
              state_d  = (count_q < CNT_W'(MIN_VERTICES)) ? ST_DONE : ST_PRIME;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PRIME: begin
        // The edge into vertex 0 starts at the last vertex.
        rd_en    = 1'b1;
        rd_addr  = n_m1[IDX_W-1:0];
        rd_first = 1'b1;
        state_d  = ST_WALK;
      end
      ST_WALK: begin
        rd_en   = 1'b1;
        rd_addr = rd_idx_q;
        if (rd_idx_q == n_m1[IDX_W-1:0]) begin
          state_d = ST_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (few_q) begin
            out_word_d.inside_res = 1'b0;
            out_word_d.status     = STATUS_FEW;
          end else begin
            out_word_d.inside_res = parity_q;
            out_word_d.status     = ovf_q ? STATUS_DROP : STATUS_OK;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory port: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Stage one: differences of the edge from the previous vertex to the current one.
  assign cur_x    = rd_data_q[MEM_W-1:COORD_W];
  assign cur_z    = rd_data_q[COORD_W-1:0];
  assign straddle = (cur_z > pz_q) != (prev_z_q > pz_q);
  assign s1_vld_d = rd_vld_q && !rd_first_q && straddle;

  // Stage three: exact cross-multiplied compare, sense set by the sign of dz.
  assign toggle   = s2_dzpos_q ? (s2_p1_q < s2_p2_q) : (s2_p1_q > s2_p2_q);

  always_comb begin
    parity_d = parity_q;
    if (in_acc && (in_word_i.func == FUNC_TEST)) begin
      parity_d = 1'b0;
    end else if (s2_vld_q && toggle) begin
      parity_d = !parity_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_word_i.func == FUNC_TEST)) begin
      px_q <= in_word_i.coord_x;
      pz_q <= in_word_i.coord_z;
    end
    if (rd_vld_q) begin
      prev_x_q <= cur_x;
      prev_z_q <= cur_z;
    end
    s1_a_q     <= $signed({px_q[COORD_W-1], px_q}) - $signed({cur_x[COORD_W-1], cur_x});
    s1_b_q     <= $signed({prev_z_q[COORD_W-1], prev_z_q})
                  - $signed({cur_z[COORD_W-1], cur_z});
    s1_c_q     <= $signed({prev_x_q[COORD_W-1], prev_x_q})
                  - $signed({cur_x[COORD_W-1], cur_x});
    s1_d_q     <= $signed({pz_q[COORD_W-1], pz_q}) - $signed({cur_z[COORD_W-1], cur_z});
    s1_dzpos_q <= (prev_z_q > cur_z);
    s2_p1_q    <= PRD_W'(s1_a_q) * PRD_W'(s1_b_q);
    s2_p2_q    <= PRD_W'(s1_c_q) * PRD_W'(s1_d_q);
    s2_dzpos_q <= s1_dzpos_q;
    out_word_q <= out_word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      few_q       <= 1'b0;
      rd_idx_q    <= '0;
      parity_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      few_q       <= few_d;
      rd_idx_q    <= rd_idx_d;
      parity_q    <= parity_d;
      rd_vld_q    <= rd_en;
      rd_first_q  <= rd_first;
      s1_vld_q    <= s1_vld_d;
      s2_vld_q    <= s1_vld_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count exceeds capacity");

  a_no_write_in_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !wr_en)
    else $error("memory written while a test walks the table");

  a_walk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (CNT_W'(rd_idx_q) < n_q))
    else $error("read index beyond stored vertices");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pipe_busy)
    else $error("edge pipeline busy while idle");

  a_few_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_word_i.func == FUNC_TEST) && (count_q < CNT_W'(MIN_VERTICES)))
      |=> (state_q == ST_DONE))
    else $error("short polygon test did not answer directly");
`endif

endmodule

@@ tb/pip_tb_pkg.sv @@
// Vertex-table predictor and answer checker for the point-in-polygon testbench.
`timescale 1ns / 100ps
package pip_tb_pkg;
  import pip_pkg::*;

  // The fourth function code, which the block must ignore.
  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  class polygon_scoreboard;
    coord_t      vert_x [MAX_VERTICES_DEF];
    coord_t      vert_z [MAX_VERTICES_DEF];
    int unsigned vert_count;
    bit          dropped;
    out_word_t   pending_answers [$];
    int unsigned error_count;

    function new();
      vert_count  = 0;
      dropped     = 1'b0;
      error_count = 0;
    endfunction

    // Even-odd parity over the stored edges, with the crossing compare done
    // exactly on 68-bit products so no division is needed.
    function bit point_inside(coord_t px, coord_t pz);
      bit                 parity;
      int unsigned        j;
      longint             qx, qz, xi, zi, xj, zj, dz;
      logic signed [67:0] lhs, rhs;
      parity = 1'b0;
      qx     = px;
      qz     = pz;
      j      = vert_count - 1;
      for (int unsigned i = 0; i < vert_count; i++) begin
        if ((vert_z[i] > pz) != (vert_z[j] > pz)) begin
          xi  = vert_x[i];
          zi  = vert_z[i];
          xj  = vert_x[j];
          zj  = vert_z[j];
          dz  = zj - zi;
          lhs = (qx - xi) * dz;
          rhs = (xj - xi) * (qz - zi);
          if ((dz > 0 && lhs < rhs) || (dz < 0 && lhs > rhs)) parity = !parity;
        end
        j = i;
      end
      return parity;
    endfunction

    function void note_word(in_word_t w);
      out_word_t answer;
      case (w.func)
        FUNC_START: begin
          vert_x[0]  = w.coord_x;
          vert_z[0]  = w.coord_z;
          vert_count = 1;
          dropped    = 1'b0;
        end
        FUNC_APPEND: begin
          if (vert_count < MAX_VERTICES_DEF) begin
            vert_x[vert_count] = w.coord_x;
            vert_z[vert_count] = w.coord_z;
            vert_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        FUNC_TEST: begin
          if (vert_count < MIN_VERTICES) begin
            answer.inside_res = 1'b0;
            answer.status     = STATUS_FEW;
          end else begin
            answer.inside_res = point_inside(w.coord_x, w.coord_z);
            answer.status     = dropped ? STATUS_DROP : STATUS_OK;
          end
          pending_answers = {pending_answers, answer};
        end
        default: ;
      endcase
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: result inside_res=%0b status=%0d arrived with no test pending",
                 $time, got.inside_res, got.status);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (got.inside_res !== want.inside_res) begin
          $display("%0t: inside_res expected %0b, got %0b",
                   $time, want.inside_res, got.inside_res);
          error_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          error_count++;
        end
      end
    endfunction
  endclass

endpackage

@@ tb/point_in_polygon_test_test.sv @@
// Top level of the point-in-polygon testbench: clock, reset, stimulus and result sink.
`timescale 1ns / 100ps
module point_in_polygon_test_test;
  import pip_pkg::*;
  import pip_tb_pkg::*;

  // Number of non-ignored words sent in the random phase.
  localparam int unsigned RANDOM_WORDS = 1150;
  // A full walk of the table plus the pipeline, with margin.
  localparam int unsigned TAIL_CYCLES  = MAX_VERTICES_DEF + 40;
  localparam coord_t      COORD_MIN    = coord_t'(32'h8000_0000);
  localparam coord_t      COORD_MAX    = coord_t'(32'h7fff_ffff);

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;

  polygon_scoreboard board = new();

  // When a side is calm it neither idles nor stalls; each side flips its
  // mode now and then so that runs of back-to-back words also occur.
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;
  int unsigned words_sent   = 0;
  int unsigned hold_left    = 0;
  int unsigned results_seen = 0;

  // The vertices of the shape being built, used to aim test points at
  // vertex heights and corners where the straddle rule matters most.
  coord_t shape_x [$];
  coord_t shape_z [$];

  point_in_polygon_test dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The run ends here if the block hangs. Even with every word a test on a
  // full table and every gap and stall at its longest, a correct run stays
  // near one millisecond, so five milliseconds is ample.
  initial begin
    #5_000_000;
    $display("point_in_polygon_test_test: done, errors");
    $finish;
  end

  // Present one word after a random gap and hold it until the block takes
  // it. Valid stays high straight into the next word when the gap is zero,
  // so it is never lowered and raised in the same step.
  task automatic send_word(logic [1:0] func, coord_t x, coord_t z);
    in_word_t    w;
    int unsigned gap;
    w.func    = func;
    w.coord_x = x;
    w.coord_z = z;
    gap       = in_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(w);
    if (func != FUNC_IGNORED) words_sent++;
  endtask

  // Style 0 keeps coordinates near the origin so that many test points fall
  // inside; style 1 spreads them over the whole range; style 2 mixes in the
  // extremes of the signed range.
  function automatic coord_t rand_coord(int unsigned style);
    coord_t v;
    case (style)
      0: v = $urandom_range(0, 4095) - 2048;
      1: v = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0:       v = COORD_MIN;
          1:       v = COORD_MAX;
          2:       v = 0;
          3:       v = -1;
          4:       v = $urandom_range(0, 4095) - 2048;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic put_vertex(logic [1:0] func, int unsigned style);
    coord_t x, z;
    x = rand_coord(style);
    z = rand_coord(style);
    if (func == FUNC_START) begin
      shape_x.delete();
      shape_z.delete();
    end
    shape_x = {shape_x, x};
    shape_z = {shape_z, z};
    send_word(func, x, z);
  endtask

  // Half the test points share a vertex's z, some sit exactly on a vertex,
  // the rest are free.
  task automatic probe(int unsigned style);
    coord_t      x, z;
    int unsigned pick, k;
    pick = $urandom_range(0, 5);
    x    = rand_coord(style);
    z    = rand_coord(style);
    if (shape_x.size() != 0 && pick < 3) begin
      k = $urandom_range(0, shape_x.size() - 1);
      z = shape_z[k];
      if (pick == 0) x = shape_x[k];
    end
    send_word(FUNC_TEST, x, z);
  endtask

  // Build a shape of n vertices, either fresh or appended to the current
  // one. A test now and then in the middle breaks the sequence on purpose.
  task automatic build_shape(int unsigned n, int unsigned style, bit extend);
    for (int unsigned k = 0; k < n; k++) begin
      put_vertex((k == 0 && !extend) ? FUNC_START : FUNC_APPEND, style);
      if ($urandom_range(0, 19) == 0) probe(style);
    end
  endtask

  initial begin
    int unsigned n, style, r, target;
    bit          first;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A test on an empty table, then appends with no start
    // fill the table from entry zero; two vertices are still too few.
    send_word(FUNC_TEST, 0, 0);
    send_word(FUNC_APPEND, 0, 0);
    send_word(FUNC_APPEND, 1024, 0);
    send_word(FUNC_TEST, 100, 100);
    send_word(FUNC_APPEND, 0, 1024);
    send_word(FUNC_TEST, 100, 100);
    // The ignored function code must neither answer nor touch the table.
    send_word(FUNC_IGNORED, COORD_MAX, COORD_MIN);
    send_word(FUNC_TEST, 2000, 100);
    // A square spanning the whole signed range, probed at its corners and
    // edges, where the differences and products are at their largest.
    send_word(FUNC_START, COORD_MIN, COORD_MIN);
    send_word(FUNC_APPEND, COORD_MAX, COORD_MIN);
    send_word(FUNC_APPEND, COORD_MAX, COORD_MAX);
    send_word(FUNC_APPEND, COORD_MIN, COORD_MAX);
    send_word(FUNC_TEST, 0, 0);
    send_word(FUNC_TEST, COORD_MIN, COORD_MIN);
    send_word(FUNC_TEST, COORD_MAX, COORD_MAX);
    send_word(FUNC_TEST, COORD_MIN, 0);
    send_word(FUNC_TEST, COORD_MAX - 1, -1);
    // A start after a full shape leaves only one vertex. Then a triangle
    // with a horizontal edge, probed at the height of that edge.
    send_word(FUNC_START, 0, 0);
    send_word(FUNC_APPEND, 256, 512);
    send_word(FUNC_TEST, 128, 512);
    send_word(FUNC_APPEND, -256, 512);
    send_word(FUNC_TEST, 0, 512);
    send_word(FUNC_TEST, 0, 256);
    send_word(FUNC_TEST, 0, 0);

    // Random part. The first shape overruns the table so that a drop is
    // always seen; later shapes are mostly small, a few are too short and a
    // few reach or pass the capacity.
    first  = 1'b1;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      style = $urandom_range(0, 2);
      r     = $urandom_range(0, 99);
      if (first) n = MAX_VERTICES_DEF + 2;
      else if (r < 8) n = $urandom_range(1, 2);
      else if (r < 13) n = $urandom_range(MAX_VERTICES_DEF - 4, MAX_VERTICES_DEF + 6);
      else n = $urandom_range(3, 12);
      build_shape(n, style, !first && $urandom_range(0, 9) == 0);
      first = 1'b0;
      if ($urandom_range(0, 7) == 0) send_word(FUNC_IGNORED, $urandom, $urandom);
      repeat ($urandom_range(1, 5)) probe(style);
      if ($urandom_range(0, 5) == 0) in_calm = !in_calm;
    end
    in_valid <= 1'b0;

    // Drain, then give any stray result time to show up.
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.error_count == 0) begin
      $display("point_in_polygon_test_test: done, clean");
    end else begin
      $display("point_in_polygon_test_test: done, errors");
    end
    $finish;
  end

  // Result sink. After each accepted word a stall length is drawn; it is
  // counted down only while a result is offered, so the stall lands on the
  // next result whatever the block's timing.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        board.check_word(out_word);
        hold_left = out_calm ? 0 : $urandom_range(0, 4);
        out_stall <= (hold_left != 0);
        results_seen++;
        if (results_seen % 37 == 0) out_calm = !out_calm;
      end else if (out_valid && hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) out_stall <= 1'b0;
      end
    end
  end

endmodule
